/* rtl/core/pcmfifo_pkg.sv */
package pcmfifo_pkg;

    // Default depth of the sample FIFO, in bytes.
    localparam int unsigned FifoCapacity = 4095;

    // Below this fill level the FIFO reports almost empty.
    localparam int unsigned AlmostEmptyLevel = 1024;

    // Arithmetic shift applied after the volume multiply.
    localparam int unsigned VolumeShift = 6;

    // Input transaction codes.
    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_FIFO_WR  = 3'd1;
    localparam logic [2:0] MODE_CTRL_WR  = 3'd2;
    localparam logic [2:0] MODE_RATE_WR  = 3'd3;
    localparam logic [2:0] MODE_CTRL_RD  = 3'd4;
    localparam logic [2:0] MODE_RATE_RD  = 3'd5;

    // Sample formats held in control bits 5..4.
    localparam logic [1:0] FMT_MONO8    = 2'd0;
    localparam logic [1:0] FMT_STEREO8  = 2'd1;
    localparam logic [1:0] FMT_MONO16   = 2'd2;
    localparam logic [1:0] FMT_STEREO16 = 2'd3;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         read_data;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               sample_valid;
        logic               fifo_almost_empty;
        logic               fifo_full;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_CAP,
        ST_ASSEMBLE,
        ST_SCALE,
        ST_FINISH
    } t_state;

    // Volume factor for the low four control bits.
    function automatic logic [6:0] volume_factor(input logic [3:0] idx);
        logic [6:0] f;
        case (idx)
            4'd0:    f = 7'd0;
            4'd1:    f = 7'd1;
            4'd2:    f = 7'd2;
            4'd3:    f = 7'd3;
            4'd4:    f = 7'd4;
            4'd5:    f = 7'd5;
            4'd6:    f = 7'd6;
            4'd7:    f = 7'd8;
            4'd8:    f = 7'd11;
            4'd9:    f = 7'd14;
            4'd10:   f = 7'd18;
            4'd11:   f = 7'd23;
            4'd12:   f = 7'd30;
            4'd13:   f = 7'd38;
            4'd14:   f = 7'd49;
            default: f = 7'd64;
        endcase
        return f;
    endfunction

    // Index of the last byte popped for a format (one, two or four bytes).
    function automatic logic [1:0] last_pop(input logic [1:0] fmt);
        logic [1:0] n;
        case (fmt)
            FMT_MONO8:    n = 2'd0;
            FMT_STEREO8:  n = 2'd1;
            FMT_MONO16:   n = 2'd1;
            default:      n = 2'd3;
        endcase
        return n;
    endfunction

endpackage

/* rtl/core/pcm_fifo_audio_player.sv */
// PCM FIFO audio player.
//
// One input channel carries bus transactions and sample ticks: the mode field
// selects a tick, a FIFO byte write, a control or rate write, or a control or
// rate read. Every accepted input transaction produces exactly one output
// transaction carrying read data, the volume-scaled left and right samples
// (ticks only), and the FIFO almost-empty and full flags after the operation.
//
// Items are processed one at a time. A bus transaction goes from idle straight
// to the finish state, a tick that pops nothing passes through the scale state,
// and a tick that pops 1, 2 or 4 bytes runs a read and a capture state per
// byte on the single-port sample memory, then the assemble and scale states.
// The finish state loads the result into the output register.
// The output register lets a new item be accepted while the previous result
// is still waiting; if the receiver stalls, the finished item waits in the
// final state and input acceptance stops until the output register drains.
//
// Reset clears the pointers, fill count, control, rate, phase and current
// samples. The sample memory itself is not cleared; only written entries are
// ever read back.
module pcm_fifo_audio_player #(
    parameter int unsigned FIFO_CAPACITY = pcmfifo_pkg::FifoCapacity
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  pcmfifo_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output pcmfifo_pkg::t_out_item o_out_item
);

    localparam int unsigned PtrW = $clog2(FIFO_CAPACITY);
    localparam int unsigned CntW = $clog2(FIFO_CAPACITY + 1);

    // Sample byte store, single port, with a registered read.
    logic [7:0] mem [FIFO_CAPACITY];
    logic [7:0] r_mem_q;

    pcmfifo_pkg::t_state r_state, n_state;

    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [5:0]      r_ctrl;
    logic [7:0]      r_rate;
    logic [7:0]      r_phase;
    logic [15:0]     r_cur_l, r_cur_r;

    logic [2:0]      r_mode;
    logic [1:0]      r_pop_idx, r_pop_last;
    logic            r_pop_hit;
    logic [7:0]      r_bytes [4];
    logic signed [23:0] r_prod_l, r_prod_r;

    logic            r_out_valid;
    pcmfifo_pkg::t_out_item r_out_item;

    logic            w_accept;
    logic            w_full;
    logic            w_empty;
    logic            w_mem_we;
    logic            w_mem_re;
    logic            w_out_load;
    logic [7:0]      w_next_phase;
    logic            w_phase_cross;
    logic [7:0]      w_cap_byte;
    logic signed [7:0] w_vol;

    assign w_accept      = i_in_valid && o_in_ready;
    assign w_full        = (r_count == CntW'(FIFO_CAPACITY));
    assign w_empty       = (r_count == '0);
    assign w_next_phase  = r_phase + r_rate;
    assign w_phase_cross = w_next_phase[7] ^ r_phase[7];
    assign w_cap_byte    = r_pop_hit ? r_mem_q : 8'd0;
    assign w_vol         = $signed({1'b0, pcmfifo_pkg::volume_factor(r_ctrl[3:0])});

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcmfifo_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.mode == pcmfifo_pkg::MODE_TICK) begin
                        n_state = w_phase_cross ? pcmfifo_pkg::ST_POP_RD
                                                : pcmfifo_pkg::ST_SCALE;
                    end else begin
                        n_state = pcmfifo_pkg::ST_FINISH;
                    end
                end
            end
            pcmfifo_pkg::ST_POP_RD:  n_state = pcmfifo_pkg::ST_POP_CAP;
            pcmfifo_pkg::ST_POP_CAP: begin
                n_state = (r_pop_idx == r_pop_last) ? pcmfifo_pkg::ST_ASSEMBLE
                                                    : pcmfifo_pkg::ST_POP_RD;
            end
            pcmfifo_pkg::ST_ASSEMBLE: n_state = pcmfifo_pkg::ST_SCALE;
            pcmfifo_pkg::ST_SCALE:    n_state = pcmfifo_pkg::ST_FINISH;
            pcmfifo_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = pcmfifo_pkg::ST_IDLE;
                end
            end
            default: n_state = pcmfifo_pkg::ST_IDLE;
        endcase
    end

    // Control strobes.
    always_comb begin
        o_in_ready = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            pcmfifo_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                w_mem_we   = i_in_valid && (i_in_item.mode == pcmfifo_pkg::MODE_FIFO_WR)
                             && !w_full;
            end
            pcmfifo_pkg::ST_POP_RD: w_mem_re = 1'b1;
            pcmfifo_pkg::ST_FINISH: w_out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // Sample memory. Writes happen only on accepted FIFO writes in the idle
    // state and reads only while popping, so the two never collide.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_wr_ptr] <= i_in_item.write_data;
        end else if (w_mem_re) begin
            r_mem_q <= mem[r_rd_ptr];
        end
    end

    // Architectural state and sequencing control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcmfifo_pkg::ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_ctrl      <= '0;
            r_rate      <= '0;
            r_phase     <= '0;
            r_cur_l     <= '0;
            r_cur_r     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                case (i_in_item.mode)
                    pcmfifo_pkg::MODE_TICK: r_phase <= w_next_phase;
                    pcmfifo_pkg::MODE_FIFO_WR: begin
                        if (!w_full) begin
                            r_wr_ptr <= (r_wr_ptr == PtrW'(FIFO_CAPACITY - 1)) ? '0
                                        : r_wr_ptr + 1'b1;
                            r_count  <= r_count + 1'b1;
                        end
                    end
                    pcmfifo_pkg::MODE_CTRL_WR: begin
                        if (i_in_item.write_data[7]) begin
                            r_wr_ptr <= '0;
                            r_rd_ptr <= '0;
                            r_count  <= '0;
                        end
                        r_ctrl <= i_in_item.write_data[5:0];
                    end
                    pcmfifo_pkg::MODE_RATE_WR: r_rate <= i_in_item.write_data;
                    default: ;
                endcase
            end

            // A pop from an empty FIFO leaves the pointers alone and yields zero.
            if (w_mem_re && !w_empty) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(FIFO_CAPACITY - 1)) ? '0
                            : r_rd_ptr + 1'b1;
                r_count  <= r_count - 1'b1;
            end

            if (r_state == pcmfifo_pkg::ST_ASSEMBLE) begin
                case (r_ctrl[5:4])
                    pcmfifo_pkg::FMT_MONO8: begin
                        r_cur_l <= {r_bytes[0], 8'd0};
                        r_cur_r <= {r_bytes[0], 8'd0};
                    end
                    pcmfifo_pkg::FMT_STEREO8: begin
                        r_cur_l <= {r_bytes[0], 8'd0};
                        r_cur_r <= {r_bytes[1], 8'd0};
                    end
                    pcmfifo_pkg::FMT_MONO16: begin
                        r_cur_l <= {r_bytes[1], r_bytes[0]};
                        r_cur_r <= {r_bytes[1], r_bytes[0]};
                    end
                    default: begin
                        r_cur_l <= {r_bytes[1], r_bytes[0]};
                        r_cur_r <= {r_bytes[3], r_bytes[2]};
                    end
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode     <= i_in_item.mode;
            r_pop_idx  <= '0;
            r_pop_last <= pcmfifo_pkg::last_pop(r_ctrl[5:4]);
        end
        if (w_mem_re) begin
            r_pop_hit <= !w_empty;
        end
        if (r_state == pcmfifo_pkg::ST_POP_CAP) begin
            r_bytes[r_pop_idx] <= w_cap_byte;
            r_pop_idx          <= r_pop_idx + 1'b1;
        end
        if (r_state == pcmfifo_pkg::ST_SCALE) begin
            r_prod_l <= $signed(r_cur_l) * w_vol;
            r_prod_r <= $signed(r_cur_r) * w_vol;
        end
        if (w_out_load) begin
            r_out_item.read_data         <= 8'd0;
            r_out_item.left_sample       <= '0;
            r_out_item.right_sample      <= '0;
            r_out_item.sample_valid      <= 1'b0;
            r_out_item.fifo_almost_empty <=
                32'(r_count) < 32'(pcmfifo_pkg::AlmostEmptyLevel);
            r_out_item.fifo_full         <= w_full;
            case (r_mode)
                pcmfifo_pkg::MODE_TICK: begin
                    // Product fits 22 bits; dropping six low bits is a floor shift.
                    r_out_item.left_sample  <=
                        r_prod_l[pcmfifo_pkg::VolumeShift +: 16];
                    r_out_item.right_sample <=
                        r_prod_r[pcmfifo_pkg::VolumeShift +: 16];
                    r_out_item.sample_valid <= 1'b1;
                end
                pcmfifo_pkg::MODE_CTRL_RD: r_out_item.read_data <= {w_full, 1'b0, r_ctrl};
                pcmfifo_pkg::MODE_RATE_RD: r_out_item.read_data <= r_rate;
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* rtl/core/pcmfifo_checker.sv */
module pcmfifo_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input pcmfifo_pkg::t_in_item  i_in_item,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input pcmfifo_pkg::t_out_item o_out_item
);

    // A pending output transaction holds its payload until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output payload changed while stalled");

    // Sample transactions never carry read data.
    a_tick_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.sample_valid |-> o_out_item.read_data == 8'd0)
        else $error("read data on a sample transaction");

    // Bus transactions carry silent samples.
    a_bus_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.sample_valid
        |-> o_out_item.left_sample == '0 && o_out_item.right_sample == '0)
        else $error("sample data on a bus transaction");

    // An accepted input transaction keeps the block busy for the next cycle.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted transaction");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind pcm_fifo_audio_player pcmfifo_checker u_pcmfifo_checker (.*);
